// ===== design/wfpd_pkg.sv =====
`timescale 1ns / 1ps

package wfpd_pkg;

    localparam int DEFAULT_TIME_WIDTH = 32;
    localparam int DEFAULT_DIST_WIDTH = 12;

    localparam int GAIN_WIDTH    = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int DRIVE_WIDTH   = 9;

    localparam int TARGET_RESET = 480;
    localparam int KP_RESET     = 256;
    localparam int KD_RESET     = 0;

    localparam int FRAC_BITS    = 16;
    localparam int Q16_ONE      = 65536;
    localparam int BASE_RIGHT   = 100;
    localparam int BASE_LEFT    = 95;
    localparam int SPEED_MAX    = 150;
    localparam int UPDATE_LIMIT = 20;

    // clamped update fits +/-20.0 in Q.16; speeds up to 150.0 in Q.16 plus sign
    localparam int UPD_WIDTH   = 22;
    localparam int SPEED_WIDTH = 25;
    localparam int WHOLE_WIDTH = 8;

    localparam logic signed [SPEED_WIDTH-1:0] SPEED_MAX_Q16 =
        SPEED_WIDTH'(SPEED_MAX * Q16_ONE);
    localparam logic signed [SPEED_WIDTH-1:0] BASE_RIGHT_Q16 =
        SPEED_WIDTH'(BASE_RIGHT * Q16_ONE);
    localparam logic signed [SPEED_WIDTH-1:0] BASE_LEFT_Q16 =
        SPEED_WIDTH'(BASE_LEFT * Q16_ONE);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_TARGET = 2'd0,
        REG_KP     = 2'd1,
        REG_KD     = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // clamp a Q.16 speed to 0..150, drop the fraction and negate
    function automatic logic signed [DRIVE_WIDTH-1:0] drive_of(
        input logic signed [SPEED_WIDTH-1:0] speed
    );
        logic [WHOLE_WIDTH-1:0] whole;
        logic [DRIVE_WIDTH-1:0] mag;
        if (speed < 0)
        begin
            whole = '0;
        end
        else if (speed > SPEED_MAX_Q16)
        begin
            whole = WHOLE_WIDTH'(SPEED_MAX);
        end
        else
        begin
            whole = speed[FRAC_BITS +: WHOLE_WIDTH];
        end
        mag = {1'b0, whole};
        return $signed(-mag);
    endfunction

endpackage

// ===== design/wfpd_channels.sv =====
`timescale 1ns / 1ps

interface wfpd_in_if #(
    parameter int DIST_WIDTH = wfpd_pkg::DEFAULT_DIST_WIDTH,
    parameter int TIME_WIDTH = wfpd_pkg::DEFAULT_TIME_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic [DIST_WIDTH-1:0] wall_dist;
    logic                  follow_left;
    logic [TIME_WIDTH-1:0] time_ms;

    modport source (output valid, output wall_dist, output follow_left, output time_ms,
                    input ready);
    modport sink   (input valid, input wall_dist, input follow_left, input time_ms,
                    output ready);
endinterface

interface wfpd_out_if ();
    logic                                      valid;
    logic                                      ready;
    logic signed [wfpd_pkg::DRIVE_WIDTH-1:0]   left_drive;
    logic signed [wfpd_pkg::DRIVE_WIDTH-1:0]   right_drive;

    modport source (output valid, output left_drive, output right_drive, input ready);
    modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

// ===== design/wfpd_div.sv =====
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module wfpd_div #(
    parameter int NUM_WIDTH = wfpd_pkg::DEFAULT_DIST_WIDTH + 4,
    parameter int DEN_WIDTH = wfpd_pkg::DEFAULT_TIME_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_WIDTH-1:0]  num,
    input  logic [DEN_WIDTH-1:0]  den,
    output wfpd_pkg::div_status_t status,
    output logic [NUM_WIDTH-1:0]  quot
);

    localparam int CNT_WIDTH = $clog2(NUM_WIDTH);

    logic [DEN_WIDTH-1:0] rem_reg, rem_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [NUM_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DEN_WIDTH:0]   trial;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_WIDTH-1]} - {1'b0, den_reg};
        if (!trial[DEN_WIDTH])
        begin
            rem_next = trial[DEN_WIDTH-1:0];
            quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[DEN_WIDTH-2:0], quo_reg[NUM_WIDTH-1]};
            quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(NUM_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = quo_reg;

endmodule

// ===== design/wall_follow_pd_speed_core.sv =====
`timescale 1ns / 1ps

// PD wall-following speed controller.
// in_ch carries one distance sample (wall_dist, unsigned Q8.4 cm), its millisecond
// timestamp and the wall side; out_ch returns one pair of negated motor commands.
// A transaction on either channel completes when valid and ready are both high.
// The configuration port writes target distance (index 0), proportional gain (1) and
// derivative gain (2) at any edge with cfg_we high; other indexes are ignored.
// One sample is processed at a time: the distance-rate divider takes one bit per
// cycle, then the two gains are applied bit-serially, then the final state clamps
// and forms the wheel speeds and loads them into the output register. The result
// becomes valid and in_ch is ready again in the same cycle.
// The result sits in an output register, so a stalled receiver holds only that
// register; the next sample is still taken and waits only at its own final cycle.
// Reset loads the register defaults (30 cm, gain 1.0, derivative gain 0) and clears
// the stored previous sample to distance 0 at time 0.
module wall_follow_pd_speed_core #(
    parameter int TIME_WIDTH = wfpd_pkg::DEFAULT_TIME_WIDTH,
    parameter int DIST_WIDTH = wfpd_pkg::DEFAULT_DIST_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    wfpd_in_if.sink                            in_ch,
    wfpd_out_if.source                         out_ch,
    input  logic                               cfg_we,
    input  logic [wfpd_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [wfpd_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

    localparam int GW            = wfpd_pkg::GAIN_WIDTH;
    localparam int NUM_WIDTH     = DIST_WIDTH + 4;
    localparam int DIFF_WIDTH    = DIST_WIDTH + 1;
    localparam int D_WIDTH       = DIST_WIDTH + 5;
    localparam int TERM_WIDTH    = D_WIDTH + 1;
    localparam int ACC_WIDTH     = DIST_WIDTH + 22;
    localparam int MAC_CNT_WIDTH = $clog2(GW);
    localparam int UW            = wfpd_pkg::UPD_WIDTH;
    localparam int SW            = wfpd_pkg::SPEED_WIDTH;

    localparam logic signed [ACC_WIDTH-1:0] UPD_HI =
        ACC_WIDTH'(wfpd_pkg::UPDATE_LIMIT * wfpd_pkg::Q16_ONE);
    localparam logic signed [ACC_WIDTH-1:0] UPD_LO = -UPD_HI;

    // configuration
    logic [DIST_WIDTH-1:0] target_reg;
    logic signed [GW-1:0]  kp_reg;
    logic signed [GW-1:0]  kd_reg;

    // previous sample
    logic [DIST_WIDTH-1:0] last_dist_reg;
    logic [TIME_WIDTH-1:0] last_time_reg;

    wfpd_pkg::state_t state_reg, state_next;

    logic in_accept;
    logic in_ready;
    logic div_start;
    logic out_load;

    // datapath
    logic signed [DIFF_WIDTH-1:0]  p_reg;
    logic                          neg_reg;
    logic                          zero_dt_reg;
    logic                          left_reg;
    logic signed [D_WIDTH-1:0]     d_reg, d_next;
    logic [GW-1:0]                 kp_sh_reg;
    logic [GW-1:0]                 kd_sh_reg;
    logic [MAC_CNT_WIDTH-1:0]      mac_cnt_reg;
    logic signed [ACC_WIDTH-1:0]   acc_reg, acc_next;

    logic                               out_valid_reg;
    logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] left_drive_reg, left_drive_next;
    logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] right_drive_reg, right_drive_next;

    logic [TIME_WIDTH-1:0]         dt;
    logic signed [DIFF_WIDTH-1:0]  delta;
    logic [DIFF_WIDTH-1:0]         delta_abs;
    logic [NUM_WIDTH-1:0]          div_num;
    logic signed [DIFF_WIDTH-1:0]  p_next;

    wfpd_pkg::div_status_t         div_stat;
    logic [NUM_WIDTH-1:0]          div_quot;
    logic [D_WIDTH-1:0]            d_mag;

    logic signed [D_WIDTH-1:0]     p16;
    logic signed [TERM_WIDTH-1:0]  term;
    logic signed [ACC_WIDTH-1:0]   term_ext;

    logic signed [ACC_WIDTH-1:0]   acc_clamped;
    logic signed [UW-1:0]          upd;
    logic signed [SW-1:0]          upd_ext;
    logic signed [SW-1:0]          right_spd;
    logic signed [SW-1:0]          left_spd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= DIST_WIDTH'(wfpd_pkg::TARGET_RESET);
            kp_reg     <= GW'(wfpd_pkg::KP_RESET);
            kd_reg     <= GW'(wfpd_pkg::KD_RESET);
        end
        else if (cfg_we)
        begin
            case (wfpd_pkg::cfg_reg_t'(cfg_index))
                wfpd_pkg::REG_TARGET: target_reg <= cfg_wdata[DIST_WIDTH-1:0];
                wfpd_pkg::REG_KP:     kp_reg     <= cfg_wdata[GW-1:0];
                wfpd_pkg::REG_KD:     kd_reg     <= cfg_wdata[GW-1:0];
                default:              ;
            endcase
        end
    end

    // sample intake: elapsed time wraps, distance change goes to the divider as |delta|*16
    always_comb
    begin
        dt        = in_ch.time_ms - last_time_reg;
        delta     = $signed({1'b0, in_ch.wall_dist}) - $signed({1'b0, last_dist_reg});
        delta_abs = delta[DIFF_WIDTH-1] ? DIFF_WIDTH'(-delta) : DIFF_WIDTH'(delta);
        div_num   = {delta_abs[DIST_WIDTH-1:0], 4'b0000};
        p_next    = $signed({1'b0, target_reg}) - $signed({1'b0, in_ch.wall_dist});
    end

    wfpd_div #(
        .NUM_WIDTH (NUM_WIDTH),
        .DEN_WIDTH (TIME_WIDTH)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (dt),
        .status (div_stat),
        .quot   (div_quot)
    );

    assign in_accept = in_ch.valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wfpd_pkg::ST_IDLE:
                if (in_accept)
                    state_next = wfpd_pkg::ST_DIV;
            wfpd_pkg::ST_DIV:
                if (div_stat.done)
                    state_next = wfpd_pkg::ST_MAC;
            wfpd_pkg::ST_MAC:
                if (mac_cnt_reg == MAC_CNT_WIDTH'(GW - 1))
                    state_next = wfpd_pkg::ST_FIN;
            wfpd_pkg::ST_FIN:
                if (!out_valid_reg || out_ch.ready)
                    state_next = wfpd_pkg::ST_IDLE;
            default:
                state_next = wfpd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == wfpd_pkg::ST_IDLE);
        div_start = in_ch.valid && (state_reg == wfpd_pkg::ST_IDLE);
        out_load  = (state_reg == wfpd_pkg::ST_FIN) && (!out_valid_reg || out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfpd_pkg::ST_IDLE;
            last_dist_reg <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                last_dist_reg <= in_ch.wall_dist;
                last_time_reg <= in_ch.time_ms;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // signed quotient, truncated toward zero; a zero interval gives zero
    always_comb
    begin
        d_mag = {1'b0, div_quot};
        if (zero_dt_reg)
            d_next = '0;
        else if (neg_reg)
            d_next = $signed(-d_mag);
        else
            d_next = $signed(d_mag);
    end

    // Horner over the gain bits, MSB first; the MSB carries negative weight
    always_comb
    begin
        p16      = $signed({p_reg, 4'b0000});
        term     = (kp_sh_reg[GW-1] ? TERM_WIDTH'(p16) : TERM_WIDTH'(0))
                 + (kd_sh_reg[GW-1] ? TERM_WIDTH'(d_reg) : TERM_WIDTH'(0));
        term_ext = ACC_WIDTH'(term);
        if (mac_cnt_reg == '0)
            acc_next = -term_ext;
        else
            acc_next = (acc_reg <<< 1) + term_ext;
    end

    always_comb
    begin
        if (acc_reg > UPD_HI)
            acc_clamped = UPD_HI;
        else if (acc_reg < UPD_LO)
            acc_clamped = UPD_LO;
        else
            acc_clamped = acc_reg;
        upd     = acc_clamped[UW-1:0];
        upd_ext = SW'(upd);
        if (left_reg)
        begin
            right_spd = wfpd_pkg::BASE_RIGHT_Q16 - upd_ext;
            left_spd  = wfpd_pkg::BASE_LEFT_Q16 + upd_ext;
        end
        else
        begin
            right_spd = wfpd_pkg::BASE_RIGHT_Q16 + upd_ext;
            left_spd  = wfpd_pkg::BASE_LEFT_Q16 - upd_ext;
        end
        left_drive_next  = wfpd_pkg::drive_of(left_spd);
        right_drive_next = wfpd_pkg::drive_of(right_spd);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_reg       <= p_next;
            neg_reg     <= delta[DIFF_WIDTH-1];
            zero_dt_reg <= (dt == '0);
            left_reg    <= in_ch.follow_left;
        end
        if ((state_reg == wfpd_pkg::ST_DIV) && div_stat.done)
        begin
            d_reg       <= d_next;
            kp_sh_reg   <= kp_reg;
            kd_sh_reg   <= kd_reg;
            mac_cnt_reg <= '0;
            acc_reg     <= '0;
        end
        else if (state_reg == wfpd_pkg::ST_MAC)
        begin
            acc_reg     <= acc_next;
            kp_sh_reg   <= {kp_sh_reg[GW-2:0], 1'b0};
            kd_sh_reg   <= {kd_sh_reg[GW-2:0], 1'b0};
            mac_cnt_reg <= mac_cnt_reg + 1'b1;
        end
        if (out_load)
        begin
            left_drive_reg  <= left_drive_next;
            right_drive_reg <= right_drive_next;
        end
    end

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_drive  = left_drive_reg;
    assign out_ch.right_drive = right_drive_reg;

    a_ready_not_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !div_stat.busy)
        else $error("input ready while divider busy");

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == wfpd_pkg::ST_DIV))
        else $error("divider result outside division phase");

    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (div_stat.busy && (state_reg == wfpd_pkg::ST_DIV)))
        else $error("accepted sample did not start division");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.left_drive <= 0 && out_ch.left_drive >= -150
                          && out_ch.right_drive <= 0 && out_ch.right_drive >= -150))
        else $error("drive command out of range");

endmodule

// ===== bench/tb_wall_follow_pd_speed_core.sv =====
`timescale 1ns / 1ps

module tb_wall_follow_pd_speed_core;

    localparam logic [wfpd_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 127;

    typedef struct packed {
        logic [11:0] dist_q4;
        logic        left;
        logic [31:0] stamp;
    } sample_t;

    typedef struct packed {
        logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] left;
        logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] right;
    } drive_pair_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [wfpd_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [wfpd_pkg::CFG_WIDTH-1:0] cfg_wdata;

    wfpd_in_if #(.DIST_WIDTH(12), .TIME_WIDTH(32)) in_ch ();
    wfpd_out_if out_ch ();

    wall_follow_pd_speed_core #(
        .TIME_WIDTH(32),
        .DIST_WIDTH(12)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // controller copy: registers and previous sample
    logic [11:0]        tgt;
    logic signed [15:0] kp;
    logic signed [15:0] kd;
    logic [11:0]        prev_dist;
    logic [31:0]        prev_stamp;

    sample_t     pending_samples[$];
    drive_pair_t expected_drives[$];
    sample_t     cur_sample;
    logic        feed_hold;
    int          burst_left;
    int          gap_left;
    int          stall_mode;
    int          mode_left;
    int          errors;
    logic [31:0] t_cursor;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] to_drive(input longint spd);
        longint c;
        logic signed [wfpd_pkg::DRIVE_WIDTH-1:0] r;
        c = spd;
        if (c < 0)
        begin
            c = 0;
        end
        else if (c > longint'(wfpd_pkg::SPEED_MAX) * wfpd_pkg::Q16_ONE)
        begin
            c = longint'(wfpd_pkg::SPEED_MAX) * wfpd_pkg::Q16_ONE;
        end
        r = wfpd_pkg::DRIVE_WIDTH'(-(c / wfpd_pkg::Q16_ONE));
        return r;
    endfunction

    // advance the controller copy by one sample and give its wheel commands
    function automatic drive_pair_t steer(input sample_t s);
        logic [31:0] gap32;
        longint dt;
        longint delta;
        longint rate;
        longint prop;
        longint upd;
        longint lim;
        longint r_spd;
        longint l_spd;
        drive_pair_t res;
        gap32 = s.stamp - prev_stamp;
        dt = longint'({32'd0, gap32});
        delta = longint'(s.dist_q4) - longint'(prev_dist);
        rate = 0;
        if (dt != 0)
        begin
            rate = (delta * 16) / dt;
        end
        prop = longint'(tgt) - longint'(s.dist_q4);
        upd = longint'(kp) * prop * 16 + longint'(kd) * rate;
        lim = longint'(wfpd_pkg::UPDATE_LIMIT) * wfpd_pkg::Q16_ONE;
        if (upd > lim)
        begin
            upd = lim;
        end
        else if (upd < -lim)
        begin
            upd = -lim;
        end
        if (s.left)
        begin
            r_spd = longint'(wfpd_pkg::BASE_RIGHT) * wfpd_pkg::Q16_ONE - upd;
            l_spd = longint'(wfpd_pkg::BASE_LEFT) * wfpd_pkg::Q16_ONE + upd;
        end
        else
        begin
            r_spd = longint'(wfpd_pkg::BASE_RIGHT) * wfpd_pkg::Q16_ONE + upd;
            l_spd = longint'(wfpd_pkg::BASE_LEFT) * wfpd_pkg::Q16_ONE - upd;
        end
        res.left = to_drive(l_spd);
        res.right = to_drive(r_spd);
        prev_stamp = s.stamp;
        prev_dist = s.dist_q4;
        return res;
    endfunction

    function automatic logic [15:0] pick_gain();
        int v;
        case ($urandom_range(0, 5))
            0: v = 32'hFFFF8000;
            1: v = 32'h00007FFF;
            2: v = 0;
            3, 4: v = int'($urandom_range(0, 1024)) - 512;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.wall_dist <= '0;
            in_ch.follow_left <= 1'b0;
            in_ch.time_ms <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_drives.push_back(steer(cur_sample));
            end
            if (in_ch.valid && !in_ch.ready)
            begin
                // hold the offered transaction
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end
            else if (!feed_hold && pending_samples.size() > 0)
            begin
                cur_sample = pending_samples.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.wall_dist <= cur_sample.dist_q4;
                in_ch.follow_left <= cur_sample.left;
                in_ch.time_ms <= cur_sample.stamp;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches at random among modes, from always ready to rarely ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= 1'($urandom_range(0, 1));
                2: out_ch.ready <= ($urandom_range(0, 7) == 0);
                default: out_ch.ready <= ($urandom_range(0, 59) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_drives.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction left %0d right %0d", $time,
                         out_ch.left_drive, out_ch.right_drive);
            end
            else
            begin
                drive_pair_t want;
                want = expected_drives.pop_front();
                if (out_ch.left_drive !== want.left)
                begin
                    errors++;
                    $display("%0t: left_drive expected %0d actual %0d", $time,
                             want.left, out_ch.left_drive);
                end
                if (out_ch.right_drive !== want.right)
                begin
                    errors++;
                    $display("%0t: right_drive expected %0d actual %0d", $time,
                             want.right, out_ch.right_drive);
                end
            end
        end
    end

    task automatic write_reg(input logic [wfpd_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            wfpd_pkg::REG_TARGET: tgt = val[11:0];
            wfpd_pkg::REG_KP:     kp = val;
            wfpd_pkg::REG_KD:     kd = val;
            default:    ;
        endcase
    endtask

    task automatic add_sample(input logic [11:0] dist_q4, input logic left,
                              input logic [31:0] stamp);
        sample_t s;
        s.dist_q4 = dist_q4;
        s.left = left;
        s.stamp = stamp;
        pending_samples.push_back(s);
    endtask

    // release the queued samples, then wait until every result is back
    task automatic run_and_drain();
        feed_hold = 1'b0;
        @(negedge clk);
        while (pending_samples.size() != 0 || in_ch.valid || expected_drives.size() != 0)
        begin
            @(negedge clk);
        end
        feed_hold = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        int v;
        logic [11:0] dist_q4;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                dist_q4 = 12'($urandom);
            end
            else
            begin
                v = int'(tgt) + int'($urandom_range(0, 800)) - 400;
                if (v < 0)
                begin
                    v = 0;
                end
                else if (v > 4095)
                begin
                    v = 4095;
                end
                dist_q4 = v[11:0];
            end
            case ($urandom_range(0, 19))
                0: ;
                1: t_cursor = $urandom;
                2: t_cursor = 32'hFFFF_FFFF - $urandom_range(0, 30);
                3, 4: t_cursor = t_cursor + 1;
                default: t_cursor = t_cursor + $urandom_range(1, 50);
            endcase
            add_sample(dist_q4, 1'($urandom_range(0, 1)), t_cursor);
        end
    endtask

    initial
    begin
        logic [15:0] val;
        errors = 0;
        feed_hold = 1'b1;
        tgt = 12'(wfpd_pkg::TARGET_RESET);
        kp = 16'(wfpd_pkg::KP_RESET);
        kd = 16'(wfpd_pkg::KD_RESET);
        prev_dist = '0;
        prev_stamp = '0;
        t_cursor = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // reset registers; first sample measured against distance 0 at time 0
        add_sample(12'd480, 1'b0, 32'd10);
        add_sample(12'd0, 1'b1, 32'd10);
        add_sample(12'd4095, 1'b0, 32'd11);
        add_sample(12'd470, 1'b1, 32'd20);
        add_sample(12'd490, 1'b0, 32'd20);
        run_and_drain();

        // derivative visible: wrap of the timestamp, zero interval, steep steps
        write_reg(wfpd_pkg::REG_TARGET, 16'd800);
        write_reg(wfpd_pkg::REG_KP, 16'd64);
        write_reg(wfpd_pkg::REG_KD, 16'd32);
        add_sample(12'd800, 1'b0, 32'hFFFF_FFF0);
        add_sample(12'd810, 1'b1, 32'h0000_0005);
        add_sample(12'd810, 1'b0, 32'h0000_0005);
        add_sample(12'd4095, 1'b1, 32'h0000_0006);
        add_sample(12'd0, 1'b0, 32'h0000_0007);
        add_sample(12'd795, 1'b1, 32'hFFFF_FFFF);
        add_sample(12'd800, 1'b0, 32'h0000_0000);
        run_and_drain();

        // extreme registers; spare index must be ignored, upper target bits dropped
        write_reg(wfpd_pkg::REG_TARGET, 16'hF000);
        write_reg(wfpd_pkg::REG_KP, 16'h8000);
        write_reg(wfpd_pkg::REG_KD, 16'h7FFF);
        write_reg(REG_SPARE, 16'hFFFF);
        add_sample(12'd4095, 1'b0, 32'd100);
        add_sample(12'd0, 1'b1, 32'd101);
        add_sample(12'd1, 1'b0, 32'hFFFF_FFFF);
        add_sample(12'd4095, 1'b1, 32'hFFFF_FFFF);
        write_reg(wfpd_pkg::REG_TARGET, 16'h0FFF);
        run_and_drain();
        write_reg(wfpd_pkg::REG_TARGET, 16'h0FFF);
        write_reg(wfpd_pkg::REG_KP, 16'h7FFF);
        write_reg(wfpd_pkg::REG_KD, 16'h8000);
        add_sample(12'd0, 1'b0, 32'd200);
        add_sample(12'd4095, 1'b1, 32'd201);
        add_sample(12'd2048, 1'b0, 32'd201);
        run_and_drain();
        t_cursor = 32'd201;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 4))
                0: val = 16'h0000;
                1: val = 16'h0FFF;
                2: val = 16'(wfpd_pkg::TARGET_RESET);
                default: val = 16'($urandom);
            endcase
            write_reg(wfpd_pkg::REG_TARGET, val);
            write_reg(wfpd_pkg::REG_KP, pick_gain());
            write_reg(wfpd_pkg::REG_KD, pick_gain());
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_SPARE, 16'($urandom));
            end
            queue_random(PHASE_ITEMS);
            run_and_drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0 && expected_drives.size() == 0)
        begin
            $display("wall_follow_pd_speed_core: match");
        end
        else
        begin
            $display("wall_follow_pd_speed_core: mismatch");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("wall_follow_pd_speed_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wfpd_pkg.sv
design/wfpd_channels.sv
design/wfpd_div.sv
design/wall_follow_pd_speed_core.sv
bench/tb_wall_follow_pd_speed_core.sv
